### rtl/core/frac_red_pkg.sv
// Package for the fraction reducer: shared constants and the command and
// status structs that join the controller and the datapath.
// No dependencies.
package frac_red_pkg;

    // Default width of the numerator and the denominator.
    localparam int VALUE_WIDTH_DEF = 32;

    // Commands from the controller to the datapath, at most one set per cycle.
    typedef struct packed {
        logic load;         // capture a new word from the input side
        logic twos_step;    // strip one common factor of two
        logic reduce_step;  // one step of the binary gcd reduction
        logic div_start;    // latch the gcd and clear the divider
        logic div_step;     // one restoring division step on both values
        logic out_load;     // move the result into the output register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic zero_in;      // one of the operands is zero
        logic both_even;    // both gcd operands are still even
        logic b_zero;       // the reduction has finished
        logic g_one;        // the gcd is one
        logic div_done;     // the last division step is in progress
    } t_dp_sts;

endpackage

### rtl/core/frac_red_dp.sv
// Datapath of the fraction reducer: binary gcd registers, two restoring
// dividers that share the gcd as divisor, and the output register.
// Depends on frac_red_pkg.
module frac_red_dp
    import frac_red_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  t_dp_cmd                i_cmd,
    output t_dp_sts                o_sts,
    input  logic [VALUE_WIDTH-1:0] i_num,
    input  logic [VALUE_WIDTH-1:0] i_den,
    output logic [VALUE_WIDTH-1:0] o_num,
    output logic [VALUE_WIDTH-1:0] o_den,
    output logic                   o_lowest
);

    localparam int K_W   = $clog2(VALUE_WIDTH + 1);
    localparam int CNT_W = $clog2(VALUE_WIDTH);

    logic [VALUE_WIDTH-1:0] r_a;
    logic [VALUE_WIDTH-1:0] r_b;
    logic [K_W-1:0]         r_k;
    logic                   r_zero;
    logic [VALUE_WIDTH-1:0] r_num;
    logic [VALUE_WIDTH-1:0] r_den;
    logic [VALUE_WIDTH-1:0] r_g;
    logic [VALUE_WIDTH-1:0] r_rem_n;
    logic [VALUE_WIDTH-1:0] r_rem_d;
    logic [CNT_W-1:0]       r_cnt;
    logic                   r_lowest;
    logic [VALUE_WIDTH-1:0] r_out_num;
    logic [VALUE_WIDTH-1:0] r_out_den;
    logic                   r_out_low;

    logic [VALUE_WIDTH-1:0] g_full;
    logic [VALUE_WIDTH:0]   trial_n;
    logic [VALUE_WIDTH:0]   trial_d;
    logic [VALUE_WIDTH:0]   diff_n;
    logic [VALUE_WIDTH:0]   diff_d;
    logic                   fit_n;
    logic                   fit_d;

    // The gcd is the odd part left in a, times the common power of two.
    assign g_full = r_a << r_k;

    // One restoring division step for each value against the same divisor.
    always_comb begin
        trial_n = {r_rem_n, r_num[VALUE_WIDTH-1]};
        trial_d = {r_rem_d, r_den[VALUE_WIDTH-1]};
        diff_n  = trial_n - {1'b0, r_g};
        diff_d  = trial_d - {1'b0, r_g};
        fit_n   = (trial_n >= {1'b0, r_g});
        fit_d   = (trial_d >= {1'b0, r_g});
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a      <= i_num;
            r_b      <= i_den;
            r_num    <= i_num;
            r_den    <= i_den;
            r_k      <= '0;
            r_lowest <= 1'b1;
            r_zero   <= (i_num == '0) || (i_den == '0);
        end else if (i_cmd.twos_step) begin
            r_a <= r_a >> 1;
            r_b <= r_b >> 1;
            r_k <= r_k + K_W'(1);
        end else if (i_cmd.reduce_step) begin
            priority if (!r_a[0]) begin
                r_a <= r_a >> 1;
            end else if (!r_b[0]) begin
                r_b <= r_b >> 1;
            end else if (r_a > r_b) begin
                r_a <= r_a - r_b;
            end else begin
                r_b <= r_b - r_a;
            end
        end else if (i_cmd.div_start) begin
            r_g      <= g_full;
            r_rem_n  <= '0;
            r_rem_d  <= '0;
            r_cnt    <= '0;
            r_lowest <= 1'b0;
        end else if (i_cmd.div_step) begin
            r_rem_n <= fit_n ? diff_n[VALUE_WIDTH-1:0] : trial_n[VALUE_WIDTH-1:0];
            r_rem_d <= fit_d ? diff_d[VALUE_WIDTH-1:0] : trial_d[VALUE_WIDTH-1:0];
            r_num   <= {r_num[VALUE_WIDTH-2:0], fit_n};
            r_den   <= {r_den[VALUE_WIDTH-2:0], fit_d};
            r_cnt   <= r_cnt + CNT_W'(1);
        end
    end

    // Output register; it holds until the controller loads the next result.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_num <= r_num;
            r_out_den <= r_den;
            r_out_low <= r_lowest;
        end
    end

    assign o_sts.zero_in   = r_zero;
    assign o_sts.both_even = !r_a[0] && !r_b[0];
    assign o_sts.b_zero    = (r_b == '0);
    assign o_sts.g_one     = (g_full == VALUE_WIDTH'(1));
    assign o_sts.div_done  = (r_cnt == CNT_W'(VALUE_WIDTH - 1));

    assign o_num    = r_out_num;
    assign o_den    = r_out_den;
    assign o_lowest = r_out_low;

endmodule

### rtl/core/frac_red_ctrl.sv
// Controller of the fraction reducer: sequences load, gcd, division and
// result hand-off, and owns the stream handshakes.
// Depends on frac_red_pkg.
module frac_red_ctrl
    import frac_red_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_TWOS,
        S_REDUCE,
        S_GSET,
        S_DIVIDE,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   can_load;

    // The output register is free when empty or being taken this cycle.
    assign can_load = !r_out_valid || i_out_ready;

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = i_sts.zero_in ? S_FINISH : S_TWOS;
            end
            S_TWOS: begin
                if (i_sts.both_even) begin
                    o_cmd.twos_step = 1'b1;
                end else begin
                    n_state = S_REDUCE;
                end
            end
            S_REDUCE: begin
                if (i_sts.b_zero) begin
                    n_state = S_GSET;
                end else begin
                    o_cmd.reduce_step = 1'b1;
                end
            end
            S_GSET: begin
                if (i_sts.g_one) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIVIDE;
                end
            end
            S_DIVIDE: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (can_load) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // A result word stays valid until the sink takes it.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

### rtl/core/fraction_reducer_top.sv
// Fraction reducer: one word in, the fraction in lowest terms out.
// After a word is accepted, a zero operand goes straight to the result; otherwise the
// block strips common factors of two, runs the binary gcd loop and, when the gcd is not
// one, divides both values by it. One word is processed at a time; the block is ready for
// the next in the cycle after the result is loaded into the output register.
// Reset (synchronous, active low) empties the output and returns to idle.
module fraction_reducer_top
    import frac_red_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // Fields from bit 0 up: numerator_in, denominator_in, zero fill.
    input  logic [((2*VALUE_WIDTH+7)/8)*8-1:0] i_s_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // Fields from bit 0 up: numerator_out, denominator_out, zero fill.
    output logic [((2*VALUE_WIDTH+7)/8)*8-1:0] o_m_axis_tdata,
    // Fields from bit 0 up: already_lowest.
    output logic                               o_m_axis_tuser
);

    localparam int DATA_W = ((2*VALUE_WIDTH+7)/8)*8;

    t_dp_cmd                cmd;
    t_dp_sts                sts;
    logic [VALUE_WIDTH-1:0] out_num;
    logic [VALUE_WIDTH-1:0] out_den;

    // Sequencing and handshakes.
    frac_red_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    // Arithmetic and result storage.
    frac_red_dp #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .i_num    (i_s_axis_tdata[VALUE_WIDTH-1:0]),
        .i_den    (i_s_axis_tdata[2*VALUE_WIDTH-1:VALUE_WIDTH]),
        .o_num    (out_num),
        .o_den    (out_den),
        .o_lowest (o_m_axis_tuser)
    );

    assign o_m_axis_tdata = DATA_W'({out_den, out_num});

endmodule

### dv/testbench.sv
// Self-checking testbench for fraction_reducer_top: drives fractions through the input
// stream and compares every reduced fraction against typed values or an in-bench gcd predictor.
// Depends on frac_red_pkg and fraction_reducer_top.
`timescale 1ns / 100ps

module testbench;
    import frac_red_pkg::*;

    localparam int VW           = VALUE_WIDTH_DEF;
    localparam int DW           = ((2*VW+7)/8)*8;
    localparam int NUM_DIRECTED = 20;
    localparam int NUM_RANDOM   = 1580;
    localparam int CALM_TAIL    = 300;   // final random words sent with no idling
    localparam int PAUSE_AT     = 700;   // random word before which the sender drains
    localparam int DRAIN_CYCLES = 4*VW + 30;
    localparam int CYCLE_LIMIT  = 1_000_000;

    typedef logic [VW-1:0] t_value;

    // One reduced fraction as it leaves the block.
    typedef struct {
        t_value num;
        t_value den;
        logic   lowest;
    } t_fraction;

    // One directed word; the typed result is used only where has_typed is set.
    typedef struct {
        t_value num;
        t_value den;
        logic   has_typed;
        t_value exp_num;
        t_value exp_den;
        logic   exp_lowest;
    } t_directed_row;

    localparam t_value VMAX = '1;

    t_directed_row directed_rows [NUM_DIRECTED] = '{
        '{32'd0,          32'd0,          1'b1, 32'd0,          32'd0,          1'b1},
        '{32'd0,          32'd5,          1'b1, 32'd0,          32'd5,          1'b1},
        '{32'd7,          32'd0,          1'b1, 32'd7,          32'd0,          1'b1},
        '{32'd0,          VMAX,           1'b1, 32'd0,          VMAX,           1'b1},
        '{VMAX,           32'd0,          1'b1, VMAX,           32'd0,          1'b1},
        '{32'd1,          32'd1,          1'b1, 32'd1,          32'd1,          1'b1},
        '{VMAX,           VMAX,           1'b1, 32'd1,          32'd1,          1'b0},
        '{VMAX,           32'd1,          1'b1, VMAX,           32'd1,          1'b1},
        '{32'd1,          VMAX,           1'b1, 32'd1,          VMAX,           1'b1},
        '{32'h8000_0000,  32'h8000_0000,  1'b1, 32'd1,          32'd1,          1'b0},
        '{32'h8000_0000,  32'h4000_0000,  1'b1, 32'd2,          32'd1,          1'b0},
        '{32'hFFFF_FFFE,  32'd2,          1'b1, 32'h7FFF_FFFF,  32'd1,          1'b0},
        '{VMAX,           32'hFFFF_FFFE,  1'b1, VMAX,           32'hFFFF_FFFE,  1'b1},
        '{32'd12,         32'd18,         1'b0, 32'd0,          32'd0,          1'b0},
        '{32'd6,          32'd9,          1'b0, 32'd0,          32'd0,          1'b0},
        '{32'hAAAA_AAAA,  32'h5555_5555,  1'b0, 32'd0,          32'd0,          1'b0},
        '{32'd4294967291, 32'd4294967279, 1'b0, 32'd0,          32'd0,          1'b0},
        '{32'd2971215073, 32'd1836311903, 1'b0, 32'd0,          32'd0,          1'b0},
        '{32'h7FFF_FFFF,  32'h3FFF_FFFF,  1'b0, 32'd0,          32'd0,          1'b0},
        '{32'h0003_0000,  32'h0005_0000,  1'b0, 32'd0,          32'd0,          1'b0}
    };

    logic            i_clk;
    logic            i_rst_n;
    logic            i_s_axis_tvalid;
    logic            o_s_axis_tready;
    logic [DW-1:0]   i_s_axis_tdata;    // Fields from bit 0 up: numerator_in, denominator_in.
    logic            o_m_axis_tvalid;
    logic            i_m_axis_tready;
    logic [DW-1:0]   o_m_axis_tdata;    // Fields from bit 0 up: numerator_out, denominator_out.
    logic            o_m_axis_tuser;    // Fields from bit 0 up: already_lowest.

    t_fraction pending_fractions [$];
    int        fail_count  = 0;
    int        cycle_count = 0;
    bit        idle_on     = 1'b1;

    fraction_reducer_top #(
        .VALUE_WIDTH (VW)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // Free-running 100 MHz clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Euclid's gcd; a zero operand or a gcd of one leaves the fraction untouched.
    function automatic t_fraction reduce_fraction(t_value num, t_value den);
        t_fraction res;
        t_value    a;
        t_value    b;
        t_value    r;
        res.num    = num;
        res.den    = den;
        res.lowest = 1'b1;
        if (num != 0 && den != 0) begin
            a = num;
            b = den;
            while (b != 0) begin
                r = a % b;
                a = b;
                b = r;
            end
            if (a > 1) begin
                res.num    = num / a;
                res.den    = den / a;
                res.lowest = 1'b0;
            end
        end
        return res;
    endfunction

    // Pick a random fraction, weighted toward shared factors so the reduction is exercised.
    function automatic void pick_fraction(output t_value num, output t_value den);
        t_value g;
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                num = $urandom;
                den = $urandom;
            end
            3, 4, 5: begin
                g   = $urandom_range(2, 65535);
                num = t_value'($urandom_range(0, VMAX / g)) * g;
                den = t_value'($urandom_range(1, VMAX / g)) * g;
            end
            6: begin
                num = ($urandom | 1) << $urandom_range(1, 31);
                den = $urandom << $urandom_range(0, 31);
            end
            7: begin
                num = $urandom_range(0, 1) ? 32'd0 : $urandom;
                den = (num != 0 || $urandom_range(0, 1)) ? 32'd0 : $urandom;
            end
            8: begin
                num = $urandom_range(0, 20);
                den = $urandom_range(0, 20);
            end
            default: begin
                num = $urandom;
                den = $urandom_range(0, 1) ? num : t_value'(1);
            end
        endcase
    endfunction

    // Offer one word, possibly after an idle burst, and log its result once it is taken.
    task automatic send_fraction(t_value num, t_value den, t_fraction result);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {den, num};
        do @(posedge i_clk); while (!o_s_axis_tready);
        pending_fractions.push_back(result);
    endtask

    // Stimulus: reset, directed table, random words, then drain and report.
    initial begin
        t_value    num;
        t_value    den;
        t_fraction typed;
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].has_typed) begin
                typed.num    = directed_rows[i].exp_num;
                typed.den    = directed_rows[i].exp_den;
                typed.lowest = directed_rows[i].exp_lowest;
            end else begin
                typed = reduce_fraction(directed_rows[i].num, directed_rows[i].den);
            end
            send_fraction(directed_rows[i].num, directed_rows[i].den, typed);
        end

        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (n == PAUSE_AT) begin
                // Let the block run completely dry once.
                i_s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
                while (pending_fractions.size() != 0) @(posedge i_clk);
            end
            if (n == NUM_RANDOM - CALM_TAIL) idle_on = 1'b0;
            pick_fraction(num, den);
            send_fraction(num, den, reduce_fraction(num, den));
        end
        i_s_axis_tvalid <= 1'b0;

        while (pending_fractions.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Result side ready: random stall bursts while idling is on, otherwise always ready.
    initial begin
        i_m_axis_tready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (idle_on && $urandom_range(0, 2) == 0) begin
                i_m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    end

    // Compare each accepted result word with the oldest pending fraction.
    always @(posedge i_clk) begin
        t_fraction want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_fractions.size() == 0) begin
                $error("result word with nothing pending: tdata=%h tuser=%b",
                       o_m_axis_tdata, o_m_axis_tuser);
                fail_count++;
            end else begin
                want = pending_fractions.pop_front();
                if (o_m_axis_tdata[VW-1:0] !== want.num) begin
                    $error("numerator_out: expected %0d, got %0d",
                           want.num, o_m_axis_tdata[VW-1:0]);
                    fail_count++;
                end
                if (o_m_axis_tdata[2*VW-1:VW] !== want.den) begin
                    $error("denominator_out: expected %0d, got %0d",
                           want.den, o_m_axis_tdata[2*VW-1:VW]);
                    fail_count++;
                end
                if (o_m_axis_tuser !== want.lowest) begin
                    $error("already_lowest: expected %0b, got %0b",
                           want.lowest, o_m_axis_tuser);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

endmodule
